FILE: hw/rtl/tkms_pkg.sv
// Package for the top-k magnitude sparsifier: widths, register map,
// sequencer state type and the saturating magnitude function.
// No dependencies.
`timescale 1ns / 1ps

package tkms_pkg;

    localparam int ENTRY_W  = 32;
    localparam int MAG_W    = 31;
    localparam int BIT_W    = 5;
    localparam int KEEP_W   = 7;
    localparam int APB_W    = 32;
    localparam int PADDR_W  = 3;

    localparam logic [KEEP_W-1:0] KEEP_RESET = 7'd64;

    // Register index, taken from paddr[2]
    localparam logic REG_KEEP_COUNT = 1'b0;

    typedef enum logic [4:0] {
        ST_LOAD   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_DECIDE = 5'b00100,
        ST_CAP    = 5'b01000,
        ST_OUT    = 5'b10000
    } state_t;

    // Absolute value; the most negative code saturates to the largest positive one
    function automatic logic [MAG_W-1:0] sat_mag(input logic [ENTRY_W-1:0] v);
        logic [ENTRY_W-1:0] neg;
        neg = ~v + ENTRY_W'(1);
        if (!v[ENTRY_W-1]) begin
            return v[MAG_W-1:0];
        end else if (neg[ENTRY_W-1]) begin
            return {MAG_W{1'b1}};
        end else begin
            return neg[MAG_W-1:0];
        end
    endfunction

endpackage

FILE: hw/rtl/tkms_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module tkms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AddrW-1:0] waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AddrW-1:0] raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/topk_magnitude_sparsifier_unit.sv
// Top level of the top-k magnitude sparsifier: load, threshold search, emission.
// Depends on tkms_pkg and tkms_ram.
//
// Load: one entry per cycle, N = MATRIX_SIDE**2 entries per matrix.
// Search: after the last entry, 31 bit passes over the store through one
//   magnitude comparator; skipped when keep_count is 0 or 1.
// Emission: each result is captured (ST_CAP), then offered until taken (ST_OUT); not
//   ready for input from the last load until the last result is taken.
// Reset: synchronous, active low; keep_count returns to 64, load count to 0;
//   the entry store is not cleared.
`timescale 1ns / 1ps

module topk_magnitude_sparsifier_unit #(
    parameter int MATRIX_SIDE = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tkms_pkg::PADDR_W-1:0]    paddr,
    input  logic [tkms_pkg::APB_W-1:0]      pwdata,
    output logic [tkms_pkg::APB_W-1:0]      prdata,
    output logic                            pready,
    // input entries
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic signed [tkms_pkg::ENTRY_W-1:0] s_entry_value,
    // results
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [tkms_pkg::ENTRY_W-1:0] m_out_value,
    output logic                            m_was_kept,
    output logic                            m_last_entry
);

    import tkms_pkg::*;

    localparam int EntryCount = MATRIX_SIDE * MATRIX_SIDE;
    localparam int AddrW      = $clog2(EntryCount);
    localparam int CntW       = $clog2(EntryCount + 1);

    state_t              state_reg, state_next;
    logic [CntW-1:0]     load_cnt_reg;
    logic [CntW-1:0]     iss_cnt_reg;
    logic [CntW-1:0]     hit_cnt_reg;
    logic [CntW-1:0]     rank_reg;
    logic                rd_pend_reg;
    logic [AddrW-1:0]    emit_idx_reg;
    logic [BIT_W-1:0]    bit_idx_reg;
    logic [KEEP_W-1:0]   keep_count_reg;
    logic                m_valid_reg;
    logic [MAG_W-1:0]    thr_reg;
    logic [MAG_W-1:0]    trial_reg;
    logic [ENTRY_W-1:0]  m_out_value_reg;
    logic                m_was_kept_reg;
    logic                m_last_entry_reg;

    logic                s_accept, m_accept, cfg_write;
    logic                load_last, rank_small, pass_ok, cmp_hit, emit_last;
    logic [CntW-1:0]     rank_sel;
    logic [MAG_W-1:0]    cmp_ref, rd_mag, thr_upd, trial_seed;
    logic [BIT_W-1:0]    bit_next;
    logic                ram_re;
    logic [AddrW-1:0]    ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;

    assign s_accept  = s_valid && s_ready;
    assign m_accept  = m_valid_reg && m_ready;
    assign cfg_write = psel && penable && pwrite && pready;

    assign load_last  = (load_cnt_reg == CntW'(EntryCount - 1));
    assign rank_sel   = (keep_count_reg > KEEP_W'(EntryCount)) ? CntW'(EntryCount)
                                                                : CntW'(keep_count_reg);
    assign rank_small = (rank_sel <= CntW'(1));
    assign emit_last  = (emit_idx_reg == AddrW'(EntryCount - 1));

    // Shared comparator: trial threshold while scanning, final threshold on emit
    assign cmp_ref = (state_reg == ST_SCAN) ? trial_reg : thr_reg;
    assign rd_mag  = sat_mag(ram_rdata);
    assign cmp_hit = (rd_mag >= cmp_ref);

    assign pass_ok    = (hit_cnt_reg >= rank_reg);
    assign thr_upd    = pass_ok ? trial_reg : thr_reg;
    assign bit_next   = bit_idx_reg - BIT_W'(1);
    assign trial_seed = thr_upd | (MAG_W'(1) << bit_next);

    always_comb begin
        state_next = state_reg;
        ram_re     = 1'b0;
        ram_raddr  = '0;
        unique case (state_reg)
            ST_LOAD: begin
                if (s_accept && load_last) begin
                    state_next = rank_small ? ST_CAP : ST_SCAN;
                    ram_re     = rank_small;
                end
            end
            ST_SCAN: begin
                ram_re    = (iss_cnt_reg != CntW'(EntryCount));
                ram_raddr = iss_cnt_reg[AddrW-1:0];
                if (!ram_re && !rd_pend_reg) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                ram_re     = (bit_idx_reg == '0);
                state_next = ram_re ? ST_CAP : ST_SCAN;
            end
            ST_CAP: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                ram_re    = m_accept && !m_last_entry_reg;
                ram_raddr = emit_idx_reg + AddrW'(1);
                if (m_accept) begin
                    state_next = m_last_entry_reg ? ST_LOAD : ST_CAP;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_LOAD;
            load_cnt_reg   <= '0;
            iss_cnt_reg    <= '0;
            hit_cnt_reg    <= '0;
            rank_reg       <= '0;
            rd_pend_reg    <= 1'b0;
            emit_idx_reg   <= '0;
            bit_idx_reg    <= '0;
            keep_count_reg <= KEEP_RESET;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_pend_reg <= (state_reg == ST_SCAN) && ram_re;
            if (cfg_write && (paddr[2] == REG_KEEP_COUNT)) begin
                keep_count_reg <= pwdata[KEEP_W-1:0];
            end
            unique case (state_reg)
                ST_LOAD: begin
                    if (s_accept) begin
                        if (load_last) begin
                            load_cnt_reg <= '0;
                            rank_reg     <= rank_sel;
                            iss_cnt_reg  <= '0;
                            hit_cnt_reg  <= '0;
                            bit_idx_reg  <= BIT_W'(MAG_W - 1);
                            emit_idx_reg <= '0;
                        end else begin
                            load_cnt_reg <= load_cnt_reg + CntW'(1);
                        end
                    end
                end
                ST_SCAN: begin
                    if (ram_re) begin
                        iss_cnt_reg <= iss_cnt_reg + CntW'(1);
                    end
                    if (rd_pend_reg && cmp_hit) begin
                        hit_cnt_reg <= hit_cnt_reg + CntW'(1);
                    end
                end
                ST_DECIDE: begin
                    iss_cnt_reg <= '0;
                    hit_cnt_reg <= '0;
                    if (bit_idx_reg != '0) begin
                        bit_idx_reg <= bit_next;
                    end
                end
                ST_CAP: begin
                    m_valid_reg <= 1'b1;
                end
                ST_OUT: begin
                    if (m_accept) begin
                        m_valid_reg  <= 1'b0;
                        emit_idx_reg <= m_last_entry_reg ? '0 : emit_idx_reg + AddrW'(1);
                    end
                end
                default: begin
                    m_valid_reg <= 1'b0;
                end
            endcase
        end
    end

    // Datapath registers, no reset
    always_ff @(posedge aclk) begin
        if ((state_reg == ST_LOAD) && s_accept && load_last) begin
            thr_reg   <= '0;
            trial_reg <= MAG_W'(1) << (MAG_W - 1);
        end
        if (state_reg == ST_DECIDE) begin
            thr_reg   <= thr_upd;
            trial_reg <= trial_seed;
        end
        if (state_reg == ST_CAP) begin
            m_out_value_reg  <= cmp_hit ? ram_rdata : '0;
            m_was_kept_reg   <= cmp_hit;
            m_last_entry_reg <= emit_last;
        end
    end

    tkms_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (EntryCount)
    ) u_store (
        .aclk  (aclk),
        .we    (s_accept),
        .waddr (load_cnt_reg[AddrW-1:0]),
        .wdata (s_entry_value),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_ready      = (state_reg == ST_LOAD);
    assign m_valid      = m_valid_reg;
    assign m_out_value  = m_out_value_reg;
    assign m_was_kept   = m_was_kept_reg;
    assign m_last_entry = m_last_entry_reg;
    assign pready       = 1'b1;
    assign prdata       = (paddr[2] == REG_KEEP_COUNT) ? APB_W'(keep_count_reg) : '0;

endmodule

FILE: hw/rtl/tkms_checker.sv
// Port-level checks for the top-k magnitude sparsifier, bound to the top level.
// Depends on tkms_pkg and topk_magnitude_sparsifier_unit.
`timescale 1ns / 1ps

module tkms_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [tkms_pkg::ENTRY_W-1:0]      m_out_value,
    input logic                              m_was_kept,
    input logic                              m_last_entry
);

    import tkms_pkg::*;

    // One matrix at a time: no input while a result is offered
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while a result is pending");

    // Hold a stalled result transaction
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_out_value)
                                   && $stable(m_was_kept) && $stable(m_last_entry)))
        else $error("result changed while stalled");

    // Dropped entries carry zero
    a_zeroed: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_was_kept) |-> (m_out_value == '0))
        else $error("dropped entry with nonzero value");

    // Taking the final result reopens the input
    a_reopen: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_entry) |=> s_ready)
        else $error("input not ready after final result");

endmodule

bind topk_magnitude_sparsifier_unit tkms_checker u_tkms_checker (.*);

FILE: sim/topk_magnitude_sparsifier_unit_tb.sv
// Self-checking testbench for topk_magnitude_sparsifier_unit: loads 8x8 matrices
// over the entry channel, programs keep_count over APB and checks every emitted entry.
// Depends on tkms_pkg and the unit's RTL.
`timescale 1ns / 1ps

module topk_magnitude_sparsifier_unit_tb;

    import tkms_pkg::*;

    localparam int MATRIX_SIDE = 8;
    localparam int ENTRIES     = MATRIX_SIDE * MATRIX_SIDE;
    localparam int REG_LSB     = 2;
    localparam int SETTLE_CYC  = 20;

    localparam logic [PADDR_W-1:0] KEEP_ADDR     = PADDR_W'({REG_KEEP_COUNT, 2'b00});
    // first address past the register map
    localparam logic [PADDR_W-1:0] UNMAPPED_ADDR = PADDR_W'(4);

    typedef struct {
        logic [ENTRY_W-1:0] value;
        logic               kept;
        logic               last;
    } sparse_result_t;

    logic                       aclk;
    logic                       aresetn;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [PADDR_W-1:0]         paddr;
    logic [APB_W-1:0]           pwdata;
    logic [APB_W-1:0]           prdata;
    logic                       pready;
    logic                       s_valid;
    logic                       s_ready;
    logic signed [ENTRY_W-1:0]  s_entry_value;
    logic                       m_valid;
    logic                       m_ready;
    logic signed [ENTRY_W-1:0]  m_out_value;
    logic                       m_was_kept;
    logic                       m_last_entry;

    // predictor state
    logic [ENTRY_W-1:0]   entry_shadow [ENTRIES];
    int                   loaded_entries;
    logic [KEEP_W-1:0]    keep_shadow;
    sparse_result_t       pending_results [$];
    sparse_result_t       want;

    logic [ENTRY_W-1:0]   matrix_buf [ENTRIES];
    logic [ENTRY_W-1:0]   tie_pool [4];
    logic [ENTRY_W-1:0]   extreme_pool [4];

    bit  gaps_on;
    bit  stalls_on;
    int  fail_count;
    int  matrices_sent;
    int  results_checked;
    int  hold;

    topk_magnitude_sparsifier_unit #(
        .MATRIX_SIDE(MATRIX_SIDE)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_entry_value (s_entry_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_value   (m_out_value),
        .m_was_kept    (m_was_kept),
        .m_last_entry  (m_last_entry)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // ---------------- predictor ----------------

    function automatic logic [MAG_W-1:0] magnitude_of(input logic [ENTRY_W-1:0] v);
        logic [ENTRY_W-1:0] neg;
        neg = -v;
        if (!v[ENTRY_W-1]) begin
            return v[MAG_W-1:0];
        end
        // most negative code has no positive twin: clamp
        if (v == {1'b1, {(ENTRY_W-1){1'b0}}}) begin
            return {MAG_W{1'b1}};
        end
        return neg[MAG_W-1:0];
    endfunction

    function automatic logic [MAG_W-1:0] rank_threshold(input logic [KEEP_W-1:0] keep);
        logic [MAG_W-1:0] ranked [ENTRIES];
        logic [MAG_W-1:0] m;
        int rank;
        int j;
        rank = (int'(keep) > ENTRIES) ? ENTRIES : int'(keep);
        if (rank <= 1) begin
            return '0;
        end
        // insertion sort, largest first
        for (int i = 0; i < ENTRIES; i++) begin
            m = magnitude_of(entry_shadow[i]);
            j = i;
            while (j > 0 && ranked[j-1] < m) begin
                ranked[j] = ranked[j-1];
                j--;
            end
            ranked[j] = m;
        end
        return ranked[rank-1];
    endfunction

    task automatic record_entry(input logic [ENTRY_W-1:0] v);
        logic [MAG_W-1:0] thr;
        sparse_result_t r;
        entry_shadow[loaded_entries] = v;
        loaded_entries++;
        if (loaded_entries == ENTRIES) begin
            thr = rank_threshold(keep_shadow);
            for (int i = 0; i < ENTRIES; i++) begin
                r.kept  = magnitude_of(entry_shadow[i]) >= thr;
                r.value = r.kept ? entry_shadow[i] : '0;
                r.last  = (i == ENTRIES - 1);
                pending_results.push_back(r);
            end
            loaded_entries = 0;
        end
    endtask

    // ---------------- result checking ----------------

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result transaction: out_value %h", m_out_value);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (m_out_value !== want.value) begin
                    $error("out_value: expected %h, got %h", want.value, m_out_value);
                    fail_count++;
                end
                if (m_was_kept !== want.kept) begin
                    $error("was_kept: expected %b, got %b", want.kept, m_was_kept);
                    fail_count++;
                end
                if (m_last_entry !== want.last) begin
                    $error("last_entry: expected %b, got %b", want.last, m_last_entry);
                    fail_count++;
                end
            end
        end
    end

    // receiver: random stall before each result
    initial begin
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            hold = stalls_on ? $urandom_range(0, 4) : 0;
            repeat (hold) begin
                @(negedge aclk);
                m_ready = 1'b0;
            end
            @(negedge aclk);
            m_ready = 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    // ---------------- drivers ----------------

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [APB_W-1:0] data);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (addr[PADDR_W-1:REG_LSB] == REG_KEEP_COUNT) begin
            keep_shadow = data[KEEP_W-1:0];
        end
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic check_keep_readback();
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = KEEP_ADDR;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata[KEEP_W-1:0] !== keep_shadow) begin
            $error("keep_count: expected %0d, got %0d", keep_shadow, prdata[KEEP_W-1:0]);
            fail_count++;
        end
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic set_keep(input logic [APB_W-1:0] data);
        apb_write(KEEP_ADDR, data);
        check_keep_readback();
    endtask

    // enter after an acceptance edge or while idle; leaves s_valid high
    task automatic send_entry(input logic [ENTRY_W-1:0] v);
        int gap;
        gap = gaps_on ? $urandom_range(0, 4) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid       = 1'b1;
        s_entry_value = v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        record_entry(v);
    endtask

    task automatic send_matrix();
        for (int i = 0; i < ENTRIES; i++) begin
            send_entry(matrix_buf[i]);
        end
        @(negedge aclk);
        s_valid = 1'b0;
        matrices_sent++;
    endtask

    // hold until every emitted entry has been checked, then let the unit go idle
    task automatic drain();
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    function automatic logic [ENTRY_W-1:0] random_entry();
        logic [ENTRY_W-1:0] v;
        case ($urandom_range(0, 3))
            0: v = $urandom;
            1: begin
                v = $urandom_range(0, 1023);
                if ($urandom_range(0, 1) == 1) v = -v;
            end
            2: v = tie_pool[$urandom_range(0, 3)];
            default: v = extreme_pool[$urandom_range(0, 3)];
        endcase
        return v;
    endfunction

    task automatic fill_random();
        for (int i = 0; i < ENTRIES; i++) begin
            matrix_buf[i] = random_entry();
        end
    endtask

    // ---------------- tests ----------------

    task automatic test_register_access();
        check_keep_readback();
        apb_write(UNMAPPED_ADDR, 32'h0000_0005);
        check_keep_readback();
        // upper data bits set, low bits all ones
        set_keep(32'hFFFF_FF7F);
        set_keep(65);
        set_keep({25'($urandom_range(0, 32'h01FF_FFFF)), KEEP_W'($urandom_range(2, 63))});
    endtask

    task automatic test_small_rank_extremes();
        set_keep($urandom_range(0, 1));
        fill_random();
        matrix_buf[0] = 32'h8000_0000;
        matrix_buf[1] = 32'h7FFF_FFFF;
        matrix_buf[2] = 32'h8000_0001;
        matrix_buf[3] = 32'h0000_0000;
        matrix_buf[4] = 32'h0000_0001;
        matrix_buf[5] = 32'hFFFF_FFFF;
        matrix_buf[6] = 32'h0001_0000;
        matrix_buf[7] = 32'hFFFF_0000;
        matrix_buf[8] = 32'h5555_5555;
        matrix_buf[9] = 32'hAAAA_AAAA;
        send_matrix();
        drain();
    endtask

    // clamped -2^31 ties in magnitude with 2^31-1 and with -(2^31-1)
    task automatic test_saturated_ties();
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        set_keep(2);
        for (int i = 0; i < ENTRIES; i++) begin
            matrix_buf[i] = $urandom_range(0, 32'h00FF_FFFF);
        end
        matrix_buf[5]  = 32'h8000_0000;
        matrix_buf[20] = 32'h7FFF_FFFF;
        matrix_buf[41] = 32'h8000_0001;
        send_matrix();
        drain();
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
    endtask

    initial begin
        aresetn         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        s_valid         = 1'b0;
        s_entry_value   = '0;
        loaded_entries  = 0;
        keep_shadow     = KEEP_RESET;
        fail_count      = 0;
        matrices_sent   = 0;
        results_checked = 0;
        gaps_on         = 1'b1;
        stalls_on       = 1'b1;
        tie_pool        = '{32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 32'hFFFC_E000};
        extreme_pool    = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0001, 32'h0000_0000};
        repeat (9) @(negedge aclk);
        aresetn = 1'b1;

        test_register_access();
        test_small_rank_extremes();
        test_saturated_ties();

        $display("Covered %0d matrices, %0d entries checked: rank 0 or 1 with extreme values,",
                 matrices_sent, results_checked);
        $display("rank 2 with clamped-magnitude ties, keep_count readback and an unmapped write.");
        if (fail_count == 0) begin
            $display("topk_magnitude_sparsifier_unit_tb OK");
        end else begin
            $display("topk_magnitude_sparsifier_unit_tb NOT OK");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("topk_magnitude_sparsifier_unit_tb NOT OK");
        $finish;
    end

endmodule
